>>> sv/rpd_pkg.sv
// Shared types, constants and width helpers for the RLE pattern decoder.
// No dependencies; every other file but rpd_if imports this package.
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int REG_WIDTH   = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [REG_WIDTH-1:0]   reg_t;

  localparam count_t COUNT_MAX = '1;

  // Characters the parser looks for
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DEAD   = 8'h62;  // 'b'
  localparam logic [7:0] CH_ALIVE  = 8'h6F;  // 'o'
  localparam logic [7:0] CH_EOL    = 8'h24;  // '$'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'

  // Configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  typedef enum logic [1:0] {
    PH_LINE_START,
    PH_COMMENT,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    OP_RESTART,
    OP_SKIP,
    OP_SPAN,
    OP_ROW,
    OP_FINISH,
    OP_ERROR
  } op_t;

  typedef enum logic [1:0] {
    KIND_SPAN  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    op_t    op;
    count_t count;
  } cmd_t;

  function automatic coord_t count_to_coord(input count_t n);
    logic [63:0] w;
    w = 64'(n);
    return w[COORD_WIDTH-1:0];
  endfunction

  function automatic coord_t reg_to_coord(input reg_t v);
    logic [63:0] w;
    w = {{(64-REG_WIDTH){v[REG_WIDTH-1]}}, v};
    return w[COORD_WIDTH-1:0];
  endfunction

  function automatic reg_t coord_to_reg(input coord_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[REG_WIDTH-1:0];
  endfunction

  function automatic reg_t count_to_reg(input count_t n);
    logic [63:0] w;
    w = 64'(n);
    return w[REG_WIDTH-1:0];
  endfunction

endpackage

>>> sv/rpd_if.sv
// Handshake channels of the RLE pattern decoder: byte input, result output,
// configuration writes. Uses no package.
`timescale 1ns / 1ps

interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic       end_of_stream;
  logic [7:0] byte_req;

  modport source (output valid, restart, end_of_stream, byte_req, input ready);
  modport sink   (input valid, restart, end_of_stream, byte_req, output ready);
endinterface

interface rpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] span_x;
  logic [31:0] span_y;
  logic [31:0] span_length;
  logic [31:0] east_bound;
  logic [31:0] south_bound;
  logic        south_valid;

  modport source (output valid, kind, span_x, span_y, span_length, east_bound,
                  south_bound, south_valid, input ready);
  modport sink   (input valid, kind, span_x, span_y, span_length, east_bound,
                  south_bound, south_valid, output ready);
endinterface

interface rpd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/rpd_cmd_fifo.sv
// Short command queue between the parser front and the execution back.
// Depends on rpd_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module rpd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rpd_pkg::cmd_t push_data,
  input  logic          pop,
  output rpd_pkg::cmd_t pop_data,
  output logic          empty,
  output logic          full
);
  import rpd_pkg::*;

  cmd_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;

  assign empty    = (fill == '0);
  assign full     = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/rpd_front.sv
// Parser front: takes pattern bytes, tracks line phase and the decimal
// count, and turns tags into commands for the queue. Depends on rpd_pkg.
`timescale 1ns / 1ps

module rpd_front (
  input  logic          clk,
  input  logic          rst,
  rpd_in_if.sink        pattern,
  input  logic          fifo_full,
  output logic          push,
  output rpd_pkg::cmd_t push_data
);
  import rpd_pkg::*;

  phase_t phase, phase_next;
  count_t run_count, run_count_next;
  logic   count_seen, count_seen_next;
  logic   finished, finished_next;

  logic                   take;
  logic [7:0]             b;
  logic [COUNT_WIDTH+3:0] acc;
  count_t                 n;

  assign pattern.ready = !fifo_full;
  assign take          = pattern.valid && pattern.ready;
  assign b             = pattern.byte_req;

  // count * 10 + digit, with room to see overflow
  assign acc = ({4'b0, run_count} << 3) + ({4'b0, run_count} << 1)
             + (COUNT_WIDTH+4)'(b[3:0]);
  assign n   = count_seen ? run_count : count_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LINE_START;
      run_count  <= '0;
      count_seen <= 1'b0;
      finished   <= 1'b0;
    end else begin
      phase      <= phase_next;
      run_count  <= run_count_next;
      count_seen <= count_seen_next;
      finished   <= finished_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    run_count_next  = run_count;
    count_seen_next = count_seen;
    finished_next   = finished;
    push            = 1'b0;
    push_data.op    = OP_ERROR;
    push_data.count = n;

    if (take) begin
      if (pattern.restart) begin
        phase_next      = PH_LINE_START;
        run_count_next  = '0;
        count_seen_next = 1'b0;
        finished_next   = 1'b0;
        push            = 1'b1;
        push_data.op    = OP_RESTART;
      end else if (finished) begin
        // drop everything until restart
      end else if (pattern.end_of_stream) begin
        finished_next = 1'b1;
        push          = 1'b1;
        push_data.op  = OP_FINISH;
      end else begin
        case (phase)
          PH_LINE_START: begin
            if (b == CH_HASH) begin
              phase_next = PH_COMMENT;
            end else if (b == CH_LF) begin
              phase_next = PH_BODY;
            end else begin
              phase_next = PH_HEADER;
            end
          end
          PH_COMMENT: begin
            if (b == CH_LF) begin
              phase_next = PH_LINE_START;
            end
          end
          PH_HEADER: begin
            if (b == CH_LF) begin
              phase_next = PH_BODY;
            end
          end
          default: begin
            if (!count_seen && (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
              // skip whitespace between tags
            end else if (b inside {[CH_ZERO:CH_NINE]}) begin
              run_count_next  = (acc[COUNT_WIDTH+3:COUNT_WIDTH] != '0)
                                ? COUNT_MAX : acc[COUNT_WIDTH-1:0];
              count_seen_next = 1'b1;
            end else begin
              run_count_next  = '0;
              count_seen_next = 1'b0;
              case (b)
                CH_DEAD: begin
                  push         = 1'b1;
                  push_data.op = OP_SKIP;
                end
                CH_ALIVE: begin
                  // zero-length span has no effect at all
                  push         = (n != '0);
                  push_data.op = OP_SPAN;
                end
                CH_EOL: begin
                  push         = 1'b1;
                  push_data.op = OP_ROW;
                end
                CH_BANG: begin
                  finished_next = 1'b1;
                  push          = 1'b1;
                  push_data.op  = OP_FINISH;
                end
                default: begin
                  finished_next = 1'b1;
                  push          = 1'b1;
                  push_data.op  = OP_ERROR;
                end
              endcase
            end
          end
        endcase
      end
    end
  end

endmodule

>>> sv/rpd_back.sv
// Execution back: applies queued commands to the cursor and bounds, holds
// the origin registers and the output result register. Depends on rpd_pkg.
`timescale 1ns / 1ps

module rpd_back (
  input  logic          clk,
  input  logic          rst,
  rpd_cfg_if.sink       cfg,
  rpd_out_if.source     result,
  input  logic          cmd_empty,
  input  rpd_pkg::cmd_t cmd,
  output logic          pop
);
  import rpd_pkg::*;

  coord_t origin_x;
  coord_t origin_y;
  coord_t cursor_x, cursor_x_next;
  coord_t cursor_y, cursor_y_next;
  coord_t east_max, east_max_next;
  logic   east_known, east_known_next;
  coord_t south_max, south_max_next;
  logic   south_known, south_known_next;

  logic   out_valid;
  kind_t  kind;
  reg_t   span_x;
  reg_t   span_y;
  reg_t   span_length;
  reg_t   east_bound;
  reg_t   south_bound;
  logic   south_valid;

  coord_t n;
  coord_t x_step;
  coord_t y_step;
  logic   gives_result;
  logic   slot_free;

  assign cfg.ready = 1'b1;

  assign n            = count_to_coord(cmd.count);
  assign x_step       = cursor_x + n;
  assign y_step       = cursor_y + n;
  assign gives_result = (cmd.op == OP_SPAN) || (cmd.op == OP_FINISH)
                     || (cmd.op == OP_ERROR);
  assign slot_free    = !out_valid || result.ready;
  assign pop          = !cmd_empty && (!gives_result || slot_free);

  assign result.valid       = out_valid;
  assign result.kind        = kind;
  assign result.span_x      = span_x;
  assign result.span_y      = span_y;
  assign result.span_length = span_length;
  assign result.east_bound  = east_bound;
  assign result.south_bound = south_bound;
  assign result.south_valid = south_valid;

  always_comb begin
    cursor_x_next    = cursor_x;
    cursor_y_next    = cursor_y;
    east_max_next    = east_max;
    east_known_next  = east_known;
    south_max_next   = south_max;
    south_known_next = south_known;
    if (pop) begin
      case (cmd.op)
        OP_RESTART: begin
          cursor_x_next    = origin_x;
          cursor_y_next    = origin_y;
          east_max_next    = '0;
          east_known_next  = 1'b0;
          south_max_next   = '0;
          south_known_next = 1'b0;
        end
        OP_SKIP, OP_SPAN: begin
          cursor_x_next = x_step;
        end
        OP_ROW: begin
          cursor_y_next = y_step;
          if (!south_known || ($signed(south_max) < $signed(y_step))) begin
            south_max_next   = y_step;
            south_known_next = 1'b1;
          end
          if (!east_known || ($signed(east_max) < $signed(cursor_x))) begin
            east_max_next   = cursor_x;
            east_known_next = 1'b1;
          end
          cursor_x_next = origin_x;
        end
        OP_FINISH: begin
          if (!east_known || ($signed(east_max) < $signed(cursor_x))) begin
            east_max_next   = cursor_x;
            east_known_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      cursor_x    <= '0;
      cursor_y    <= '0;
      east_max    <= '0;
      east_known  <= 1'b0;
      south_max   <= '0;
      south_known <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_ORIGIN_X: origin_x <= reg_to_coord(cfg.data);
          CFG_ORIGIN_Y: origin_y <= reg_to_coord(cfg.data);
          default:      origin_x <= origin_x;
        endcase
      end
      cursor_x    <= cursor_x_next;
      cursor_y    <= cursor_y_next;
      east_max    <= east_max_next;
      east_known  <= east_known_next;
      south_max   <= south_max_next;
      south_known <= south_known_next;
      if (pop && gives_result) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; zero the fields a kind does not use
  always_ff @(posedge clk) begin
    if (pop && gives_result) begin
      case (cmd.op)
        OP_SPAN: begin
          kind        <= KIND_SPAN;
          span_x      <= coord_to_reg(cursor_x);
          span_y      <= coord_to_reg(cursor_y);
          span_length <= count_to_reg(cmd.count);
          east_bound  <= '0;
          south_bound <= '0;
          south_valid <= 1'b0;
        end
        OP_FINISH: begin
          kind        <= KIND_DONE;
          span_x      <= '0;
          span_y      <= '0;
          span_length <= '0;
          east_bound  <= coord_to_reg(east_max_next);
          south_bound <= coord_to_reg(south_max);
          south_valid <= south_known;
        end
        default: begin
          kind        <= KIND_ERROR;
          span_x      <= '0;
          span_y      <= '0;
          span_length <= '0;
          east_bound  <= '0;
          south_bound <= '0;
          south_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> sv/rle_pattern_decoder.sv
// RLE pattern decoder, one byte per cycle: an input byte is taken every cycle
// that the four-entry command queue has room, and the back part retires one
// queued command per cycle unless its result finds the output slot busy; a
// result is queued, then registered; sustained rate is one byte per cycle
// while results are taken. Origins apply at restart, origin_x also at row ends.
// Top level; depends on rpd_pkg, rpd_if, rpd_front, rpd_cmd_fifo, rpd_back.
`timescale 1ns / 1ps

module rle_pattern_decoder (
  input  logic      clk,
  input  logic      rst,
  rpd_in_if.sink    pattern,
  rpd_cfg_if.sink   cfg,
  rpd_out_if.source result
);
  import rpd_pkg::*;

  logic push;
  cmd_t push_data;
  logic pop;
  cmd_t pop_data;
  logic cmd_empty;
  logic cmd_full;

  rpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pattern   (pattern),
    .fifo_full (cmd_full),
    .push      (push),
    .push_data (push_data)
  );

  rpd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (cmd_empty),
    .full      (cmd_full)
  );

  rpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .result    (result),
    .cmd_empty (cmd_empty),
    .cmd       (pop_data),
    .pop       (pop)
  );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for rle_pattern_decoder: random RLE patterns in, spans and done/error
// results checked against an in-bench parser model. Depends on rpd_pkg, rpd_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import rpd_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_TOTAL  = 1900;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     span_x;
    coord_t     span_y;
    count_t     span_length;
    coord_t     east_bound;
    coord_t     south_bound;
    logic       south_valid;
  } decoded_t;

  // Parser model plus the queue of results it still owes
  class rle_span_scoreboard;
    coord_t   org_x, org_y;
    phase_t   ph;
    count_t   run_cnt;
    bit       cnt_seen;
    coord_t   cur_x, cur_y;
    coord_t   east_max, south_max;
    bit       east_known, south_known;
    bit       finished;
    decoded_t due_results[$];
    int       errors;

    function new();
      org_x = '0;
      org_y = '0;
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      ph = PH_LINE_START;
      run_cnt = '0;
      cnt_seen = 0;
      cur_x = org_x;
      cur_y = org_y;
      east_max = '0;
      east_known = 0;
      south_max = '0;
      south_known = 0;
      finished = 0;
    endfunction

    function void set_origin(logic idx, reg_t v);
      if (idx == CFG_ORIGIN_X) org_x = v;
      else org_y = v;
    endfunction

    function void note_east();
      if (!east_known || $signed(east_max) < $signed(cur_x)) begin
        east_max = cur_x;
        east_known = 1;
      end
    endfunction

    function void push(kind_t k, coord_t sx, coord_t sy, count_t len, coord_t e, coord_t s,
                       bit sv);
      decoded_t d;
      d.kind = k;
      d.span_x = sx;
      d.span_y = sy;
      d.span_length = len;
      d.east_bound = e;
      d.south_bound = s;
      d.south_valid = sv;
      due_results.push_back(d);
    endfunction

    function void finish_ok();
      note_east();
      finished = 1;
      push(KIND_DONE, '0, '0, '0, east_max, south_max, south_known);
    endfunction

    function void note_transfer(bit rs, bit eos, logic [7:0] b);
      logic [63:0] wide;
      count_t      n;
      if (rs) begin
        clear_parse();
        return;
      end
      if (finished) return;
      if (eos) begin
        finish_ok();
        return;
      end
      case (ph)
        PH_LINE_START: begin
          if (b == CH_HASH) ph = PH_COMMENT;
          else if (b == CH_LF) ph = PH_BODY;
          else ph = PH_HEADER;
          return;
        end
        PH_COMMENT: begin
          if (b == CH_LF) ph = PH_LINE_START;
          return;
        end
        PH_HEADER: begin
          if (b == CH_LF) ph = PH_BODY;
          return;
        end
        default: ;
      endcase
      if (!cnt_seen && (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)) return;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        wide = 64'(run_cnt) * 64'd10 + 64'(b - CH_ZERO);
        run_cnt = (wide > 64'(COUNT_MAX)) ? COUNT_MAX : wide[COUNT_WIDTH-1:0];
        cnt_seen = 1;
        return;
      end
      n = cnt_seen ? run_cnt : count_t'(1);
      run_cnt = '0;
      cnt_seen = 0;
      case (b)
        CH_DEAD: cur_x = cur_x + n;
        CH_ALIVE: begin
          if (n != 0) begin
            push(KIND_SPAN, cur_x, cur_y, n, '0, '0, 0);
            cur_x = cur_x + n;
          end
        end
        CH_EOL: begin
          cur_y = cur_y + n;
          if (!south_known || $signed(south_max) < $signed(cur_y)) begin
            south_max = cur_y;
            south_known = 1;
          end
          note_east();
          cur_x = org_x;
        end
        CH_BANG: finish_ok();
        default: begin
          finished = 1;
          push(KIND_ERROR, '0, '0, '0, '0, '0, 0);
        end
      endcase
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h actual %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, coord_t sx, coord_t sy, count_t len,
                               coord_t e, coord_t s, logic sv);
      decoded_t d;
      if (due_results.size() == 0) begin
        $error("kind: expected none actual %0d", kind);
        errors++;
        return;
      end
      d = due_results.pop_front();
      compare("kind", 32'(d.kind), 32'(kind));
      compare("span_x", d.span_x, sx);
      compare("span_y", d.span_y, sy);
      compare("span_length", d.span_length, len);
      compare("east_bound", d.east_bound, e);
      compare("south_bound", d.south_bound, s);
      compare("south_valid", 32'(d.south_valid), 32'(sv));
    endfunction
  endclass

  logic clk;
  logic rst;

  rpd_in_if  in_ch ();
  rpd_cfg_if cfg_ch ();
  rpd_out_if out_ch ();

  rle_pattern_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .pattern(in_ch),
    .cfg    (cfg_ch),
    .result (out_ch)
  );

  rle_span_scoreboard sb = new();

  int in_idle_pct  = 9;
  int out_idle_pct = 81;
  int items_sent   = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.kind, out_ch.span_x, out_ch.span_y, out_ch.span_length,
                      out_ch.east_bound, out_ch.south_bound, out_ch.south_valid);
  end

  // Starts at a fresh falling edge; leaves valid high for a back-to-back follower
  task automatic send(input bit rs, input bit eos, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.restart <= rs;
    in_ch.end_of_stream <= eos;
    in_ch.byte_req <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_transfer(rs, eos, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(0, 0, b);
  endtask

  task automatic cfg_write(input logic idx, input reg_t v);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_origin(idx, v);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  // Hold off until the decoder has retired everything it took
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic reg_t pick_origin();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return reg_t'($urandom_range(40)) - 32'd20;
      default: return reg_t'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] non_lf_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == CH_LF) ? 8'h41 : b;
  endfunction

  task automatic send_count();
    int sel;
    int ndig;
    sel = $urandom_range(9);
    if (sel < 4) return;
    if (sel == 4) begin
      send_byte(CH_ZERO);
      return;
    end
    // long counts can push the run length into saturation
    ndig = (sel == 5) ? $urandom_range(10, 12) : $urandom_range(1, 3);
    send_byte(CH_ZERO + 8'($urandom_range(1, 9)));
    repeat (ndig - 1) send_byte(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic send_pattern();
    int ntok;
    int r;
    send(1, $urandom_range(3) == 0, 8'($urandom));
    repeat ($urandom_range(2)) begin
      send_byte(CH_HASH);
      repeat ($urandom_range(6)) send_byte(non_lf_byte());
      send_byte(CH_LF);
    end
    if ($urandom_range(7) != 0) begin
      r = $urandom;
      send_byte((8'(r) == CH_HASH || 8'(r) == CH_LF) ? 8'h78 : 8'(r));
      repeat ($urandom_range(8)) send_byte(non_lf_byte());
    end
    send_byte(CH_LF);
    ntok = $urandom_range(1, 12);
    repeat (ntok) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_byte(8'($urandom));
      end else begin
        if (r < 20) repeat ($urandom_range(1, 2)) send_byte(pick_ws());
        send_count();
        r = $urandom_range(99);
        if (r < 3) send_byte(pick_ws());
        else if (r < 50) send_byte(CH_ALIVE);
        else if (r < 80) send_byte(CH_DEAD);
        else send_byte(CH_EOL);
      end
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: send_byte(CH_BANG);
      6, 7: send(0, 1, 8'($urandom));
      8: ;
      default: send_byte(8'($urandom));
    endcase
    repeat ($urandom_range(2)) send(0, $urandom_range(1), 8'($urandom));
  endtask

  task automatic run_phase(input int in_pct, input int out_pct, input int upto,
                           input reg_t ox, input reg_t oy);
    drain();
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    while (items_sent < upto) begin
      send_pattern();
      if ($urandom_range(3) == 0) begin
        drain();
        if ($urandom_range(1)) cfg_write(CFG_ORIGIN_X, pick_origin());
        if ($urandom_range(1)) cfg_write(CFG_ORIGIN_Y, pick_origin());
      end
    end
  endtask

  initial begin
    rst = 1;
    in_ch.valid = 0;
    in_ch.restart = 0;
    in_ch.end_of_stream = 0;
    in_ch.byte_req = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_ORIGIN_X;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    cfg_write(CFG_ORIGIN_X, 32'h0);
    cfg_write(CFG_ORIGIN_Y, 32'h0);

    // comment, header, spans, zero-length span, skip, row end, finish, then ignored input
    send(1, 0, 8'h00);
    send_byte(CH_HASH);
    send_byte(CH_LF);
    send_byte(8'h78);
    send_byte(CH_LF);
    send_byte(CH_ZERO + 8'd2);
    send_byte(CH_ALIVE);
    send_byte(CH_ZERO);
    send_byte(CH_ALIVE);
    send_byte(CH_DEAD);
    send_byte(CH_EOL);
    send_byte(CH_ALIVE);
    send_byte(CH_BANG);
    send_byte(CH_ALIVE);
    send(0, 1, 8'hFF);
    // restart wins over end of stream; 0xFF in the body is a bad tag
    send(1, 1, 8'hFF);
    send_byte(CH_LF);
    send_byte(8'hFF);
    // whitespace after a count is a bad tag
    send(1, 0, 8'h00);
    send_byte(CH_LF);
    send_byte(CH_ZERO + 8'd3);
    send_byte(CH_TAB);
    // end of stream while still in the header
    send(1, 0, 8'h00);
    send_byte(8'h00);
    send(0, 1, 8'h00);

    run_phase(9, 81, ITEMS_TOTAL / 3, 32'h0000_0000, 32'h0000_0000);
    run_phase(81, 9, 2 * ITEMS_TOTAL / 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_phase(0, 0, ITEMS_TOTAL, 32'h8000_0000, 32'h8000_0000);

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rpd_pkg.sv
sv/rpd_if.sv
sv/rpd_cmd_fifo.sv
sv/rpd_front.sv
sv/rpd_back.sv
sv/rle_pattern_decoder.sv
tb/sv/tb_top.sv
